// ===== rtl/bimaxwellian_density_eval_top_assert.svh =====
// ----------------------------------------------------------------------------
// Bi-Maxwellian evaluator assertion macros
// Shared wrappers for the concurrent checks placed at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef BIMAXWELLIAN_DENSITY_EVAL_TOP_ASSERT_SVH
`define BIMAXWELLIAN_DENSITY_EVAL_TOP_ASSERT_SVH

// Same-cycle implication, switched off while reset is asserted.
`define BDE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bde: check failed");

// Next-cycle implication, live during reset as well.
`define BDE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("bde: check failed");

`endif

// ===== rtl/bde_pkg.sv =====
// ----------------------------------------------------------------------------
// Bi-Maxwellian evaluator package
// Beat types, pipeline depths and fixed-point constants shared by all modules.
// ----------------------------------------------------------------------------
package bde_pkg;

    typedef struct packed {
        logic signed [31:0] density;
        logic signed [31:0] temp_par;
        logic signed [31:0] temp_perp;
        logic signed [31:0] vel_par;
        logic signed [31:0] vel_perp_a;
        logic signed [31:0] vel_perp_b;
        logic signed [31:0] drift_par;
        logic signed [31:0] drift_perp_a;
        logic signed [31:0] drift_perp_b;
    } t_in_item;

    typedef struct packed {
        logic [31:0] value;
        logic        nonphysical;
    } t_out_item;

    // Classified beat held in the queue between front and back.
    typedef struct packed {
        t_in_item   item;
        logic       nonphys;
        logic [1:0] vdim;
    } t_work;

    typedef struct packed {
        logic vld;
        logic nonphys;
        logic [1:0] vdim;
    } t_side;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    localparam int LOG_W = 29;
    typedef struct packed {
        logic [LOG_W-1:0] ln;
        logic [LOG_W-1:0] lt;
        logic [LOG_W-1:0] lp;
    } t_logs;

    // Register map
    localparam logic REG_VEL_DIMS = 1'b0;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    // Pipeline structure
    localparam int DIV_QBITS  = 27;
    localparam int DIV_LAT    = DIV_QBITS + 2;
    localparam int FRAC_BITS  = 24;
    localparam int LOG_LAT    = FRAC_BITS + 1;
    localparam int X_TIER     = DIV_LAT + 1;
    localparam int Y_TIER     = X_TIER + 2;
    localparam int G_TIER     = Y_TIER + 1;
    localparam int EXP_TERMS  = 10;
    localparam int EXP_STAGES = 3 * EXP_TERMS;
    localparam int LAST_TIER  = G_TIER + EXP_STAGES;
    localparam int LOG_DLY    = X_TIER - LOG_LAT;

    // Fixed-point constants
    localparam logic [26:0] X_CAP     = 27'h400_0000;
    localparam logic [28:0] LOG2E_Q28 = 29'd387270501;
    localparam logic [29:0] LN2_Q30   = 30'd744261118;
    localparam logic [31:0] ONE_Q30   = 32'h4000_0000;
    localparam logic signed [35:0] Y_K  = 36'sd291059597;
    localparam logic signed [35:0] Y_K2 = Y_K * 2;
    localparam logic signed [35:0] Y_K3 = Y_K * 3;

    // floor(2^34 / k) for the Horner divisions
    localparam int RECIP_SHIFT = 34;
    localparam logic [34:0] EXP_RECIP [1:EXP_TERMS] = '{
        35'd17179869184, 35'd8589934592, 35'd5726623061, 35'd4294967296,
        35'd3435973836,  35'd2863311530, 35'd2454267026, 35'd2147483648,
        35'd1908874353,  35'd1717986918
    };

endpackage

// ===== rtl/bimaxwellian_density_eval_top.sv =====
// Path: a pushed beat passes the front register, the queue, the back-end pipeline and the result register.
// Throughput: one beat per cycle, set by the fully pipelined back end (one quotient bit or
// one logarithm bit per stage, three stages per series term); pop back-pressure stalls it.
// Reset: synchronous, active low; empties the front register, the queue and every stage,
// and sets vel_dims to 3. Payload registers are not cleared.
// ----------------------------------------------------------------------------
// Bi-Maxwellian density evaluator, top level
// Queue-style input and result channels, APB-style configuration port, and a
// decoupled front end, queue and arithmetic back end.
// ----------------------------------------------------------------------------
`include "bimaxwellian_density_eval_top_assert.svh"

module bimaxwellian_density_eval_top import bde_pkg::*; #(
    parameter int MAX_VEL_DIMS = 3
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input channel
    input  logic        push,
    output logic        full,
    input  t_in_item    i_item,
    // Result channel
    output logic        empty,
    input  logic        pop,
    output t_out_item   o_result,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // The single register, vel_dims, sits at byte address 0. Only the word
    // index (address bit 2) is decoded; writes to any other index are dropped.
    logic [1:0] r_vel_dims;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_VEL_DIMS) ? {30'b0, r_vel_dims} : 32'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vel_dims <= 2'd3;
        end else if (cfg_wr && (paddr[2] == REG_VEL_DIMS)) begin
            r_vel_dims <= pwdata[1:0];
        end
    end

    // The front end registers a beat, flags non-positive density or
    // temperature, and resolves the dimension count against the current
    // register value so that later writes do not touch beats in flight.
    t_q_status w_q_stat;
    logic      w_q_push, w_q_pop;
    t_work     w_front_work, w_head_work;

    bde_front #(.MAX_VEL_DIMS(MAX_VEL_DIMS)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_full     (full),
        .i_item     (i_item),
        .i_vel_dims (r_vel_dims),
        .i_q_stat   (w_q_stat),
        .o_q_push   (w_q_push),
        .o_work     (w_front_work)
    );

    // The queue lets the front keep accepting while the back end is held by
    // a consumer that does not pop.
    bde_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_work  (w_front_work),
        .i_pop   (w_q_pop),
        .o_work  (w_head_work),
        .o_stat  (w_q_stat)
    );

    // The back end advances as one pipeline whenever its result register is
    // free or being popped. It forms the log2 of the result in Q.25 and then
    // raises two to that power with a ten-term series for the fraction.
    bde_back #(.MAX_VEL_DIMS(MAX_VEL_DIMS)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_work   (w_head_work),
        .i_q_stat (w_q_stat),
        .o_q_pop  (w_q_pop),
        .i_pop    (pop),
        .o_empty  (empty),
        .o_result (o_result)
    );

    // A non-physical beat always reads as zero.
    `BDE_ASSERT_IMP(a_nonphys_zero, !empty && o_result.nonphysical, o_result.value == 32'd0)
    // The front never writes into a full queue.
    `BDE_ASSERT_IMP(a_no_overflow, w_q_push, !w_q_stat.full)
    // Reset leaves both channels idle.
    `BDE_ASSERT_NEXT(a_reset_idle, !i_rst_n, empty && !full)

endmodule

// ===== rtl/bde_front.sv =====
// ----------------------------------------------------------------------------
// Bi-Maxwellian evaluator front end
// Registers each input beat, flags non-positive moments and resolves the
// dimension count before handing the beat to the queue.
// ----------------------------------------------------------------------------
module bde_front import bde_pkg::*; #(
    parameter int MAX_VEL_DIMS = 3
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    output logic      o_full,
    input  t_in_item  i_item,
    input  logic [1:0] i_vel_dims,
    input  t_q_status i_q_stat,
    output logic      o_q_push,
    output t_work     o_work
);

    localparam logic [1:0] MAXV = 2'(MAX_VEL_DIMS);

    logic  r_vld, n_vld;
    t_work r_work, n_work;
    logic  accept;

    assign o_full   = r_vld && i_q_stat.full;
    assign accept   = i_push && !o_full;
    assign o_q_push = r_vld && !i_q_stat.full;
    assign o_work   = r_work;

    always_comb begin
        n_vld        = accept || (r_vld && i_q_stat.full);
        n_work.item  = i_item;
        n_work.nonphys = ($signed(i_item.density) <= 0) || ($signed(i_item.temp_par) <= 0)
                      || ($signed(i_item.temp_perp) <= 0);
        if (i_vel_dims == 2'd0) begin
            n_work.vdim = 2'd1;
        end else if (i_vel_dims > MAXV) begin
            n_work.vdim = MAXV;
        end else begin
            n_work.vdim = i_vel_dims;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_work <= n_work;
        end
    end

endmodule

// ===== rtl/bde_queue.sv =====
// ----------------------------------------------------------------------------
// Bi-Maxwellian evaluator decoupling queue
// Small register FIFO that lets the front and back stall independently.
// ----------------------------------------------------------------------------
module bde_queue import bde_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_work     i_work,
    input  logic      i_pop,
    output t_work     o_work,
    output t_q_status o_stat
);

    t_work            r_mem [0:QUEUE_DEPTH-1];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QPTR_W:0]   r_cnt;

    assign o_stat.full  = (r_cnt == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_work       = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_work;
        end
    end

endmodule

// ===== rtl/bde_log2.sv =====
// ----------------------------------------------------------------------------
// Bi-Maxwellian evaluator base-2 logarithm
// Normalises a positive 31-bit integer, then resolves one fraction bit per
// stage by squaring the mantissa. Result is Q.24, truncated.
// ----------------------------------------------------------------------------
module bde_log2 import bde_pkg::*; (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [30:0]      i_val,
    output logic [LOG_W-1:0] o_log
);

    logic [4:0]  pos;
    logic [30:0] norm;
    logic [30:0] w_m [0:FRAC_BITS];
    logic [4:0]  w_p [0:FRAC_BITS];
    logic [FRAC_BITS-1:0] w_f [0:FRAC_BITS];
    logic [30:0] r_m0;
    logic [4:0]  r_p0;

    always_comb begin
        pos = '0;
        for (int b = 0; b < 31; b++) begin
            if (i_val[b]) begin
                pos = 5'(b);
            end
        end
        norm = i_val << (5'd30 - pos);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m0 <= norm;
            r_p0 <= pos;
        end
    end

    assign w_m[0] = r_m0;
    assign w_p[0] = r_p0;
    assign w_f[0] = '0;

    for (genvar j = 0; j < FRAC_BITS; j++) begin : g_sq
        logic [61:0] sq;
        logic [31:0] sq_hi;
        logic [30:0] r_m;
        logic [4:0]  r_p;
        logic [FRAC_BITS-1:0] r_f;

        assign sq    = w_m[j] * w_m[j];
        assign sq_hi = sq[61:30];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_m <= sq_hi[31] ? sq_hi[31:1] : sq_hi[30:0];
                r_f <= {w_f[j][FRAC_BITS-2:0], sq_hi[31]};
                r_p <= w_p[j];
            end
        end

        assign w_m[j+1] = r_m;
        assign w_p[j+1] = r_p;
        assign w_f[j+1] = r_f;
    end

    assign o_log = {w_p[FRAC_BITS], w_f[FRAC_BITS]};

endmodule

// ===== rtl/bde_sqdiv.sv =====
// ----------------------------------------------------------------------------
// Bi-Maxwellian evaluator squared-offset ratio
// Forms (v - u)^2 and divides it by 2T with a restoring divider that settles
// one quotient bit per stage. The ratio is capped at 64.0 in Q.20.
// ----------------------------------------------------------------------------
module bde_sqdiv import bde_pkg::*; (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_vel,
    input  logic [31:0] i_drift,
    input  logic [31:0] i_temp,
    output logic [26:0] o_ratio
);

    logic signed [32:0] diff;
    logic [32:0] mag;
    logic [65:0] prod;
    logic [64:0] r_prod;
    logic [32:0] r_den;

    logic [64:0] w_rem [0:DIV_QBITS];
    logic [32:0] w_den [0:DIV_QBITS];
    logic [26:0] w_q   [0:DIV_QBITS];
    logic        w_ov  [0:DIV_QBITS];
    logic [64:0] r_rem0;
    logic [32:0] r_den0;
    logic        r_ov0;

    assign diff = $signed({i_vel[31], i_vel}) - $signed({i_drift[31], i_drift});
    assign mag  = diff[32] ? 33'(-diff) : 33'(diff);
    assign prod = mag * mag;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= prod[64:0];
            r_den  <= {i_temp, 1'b0};
            r_rem0 <= r_prod;
            r_den0 <= r_den;
            r_ov0  <= r_prod >= {5'b0, r_den, 27'b0};
        end
    end

    assign w_rem[0] = r_rem0;
    assign w_den[0] = r_den0;
    assign w_q[0]   = '0;
    assign w_ov[0]  = r_ov0;

    for (genvar j = 0; j < DIV_QBITS; j++) begin : g_bit
        localparam int B = DIV_QBITS - 1 - j;
        logic [64:0] sub;
        logic        ge;
        logic [26:0] q_n;
        logic [64:0] r_rem;
        logic [32:0] r_dn;
        logic [26:0] r_q;
        logic        r_ov;

        assign sub = {32'b0, w_den[j]} << B;
        assign ge  = w_rem[j] >= sub;

        always_comb begin
            q_n    = w_q[j];
            q_n[B] = ge;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem <= ge ? (w_rem[j] - sub) : w_rem[j];
                r_q   <= q_n;
                r_dn  <= w_den[j];
                r_ov  <= w_ov[j];
            end
        end

        assign w_rem[j+1] = r_rem;
        assign w_den[j+1] = r_dn;
        assign w_q[j+1]   = r_q;
        assign w_ov[j+1]  = r_ov;
    end

    assign o_ratio = (w_ov[DIV_QBITS] || (w_q[DIV_QBITS] > X_CAP)) ? X_CAP : w_q[DIV_QBITS];

endmodule

// ===== rtl/bde_back.sv =====
// ----------------------------------------------------------------------------
// Bi-Maxwellian evaluator back end
// Takes classified beats from the queue and runs the fixed-point pipeline:
// ratios, logarithms, exponent assembly, power of two and the result register.
// ----------------------------------------------------------------------------
module bde_back import bde_pkg::*; #(
    parameter int MAX_VEL_DIMS = 3
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_work     i_work,
    input  t_q_status i_q_stat,
    output logic      o_q_pop,
    input  logic      i_pop,
    output logic      o_empty,
    output t_out_item o_result
);

    typedef struct packed {
        logic [29:0] g;
        logic [4:0]  sh;
        logic        zero;
        logic        sat;
    } t_exp_side;

    logic      en;
    logic      r_a_vld;
    t_work     r_a;
    t_side     r_sb [1:LAST_TIER];
    logic      r_out_vld;
    t_out_item r_out, n_out;

    logic [31:0] w_vel [0:2];
    logic [31:0] w_drift [0:2];
    logic [31:0] w_temp [0:2];
    logic [26:0] w_ratio [0:2];
    logic [LOG_W-1:0] w_ln, w_lt, w_lp;
    t_logs r_lg [1:LOG_DLY];

    logic [28:0] xsum;
    logic [26:0] r_x;
    logic [55:0] xprod;
    logic [32:0] r_xl;
    logic signed [35:0] ylog, r_ylog, r_y;
    logic [54:0] gprod;
    t_exp_side n_gi;
    t_exp_side r_gi [0:EXP_STAGES];
    logic [31:0] w_t [0:EXP_TERMS];
    logic [62:0] shifted;

    assign en       = !r_out_vld || i_pop;
    assign o_q_pop  = en && !i_q_stat.empty;
    assign o_empty  = !r_out_vld;
    assign o_result = r_out;

    assign w_vel[0]   = r_a.item.vel_par;
    assign w_vel[1]   = r_a.item.vel_perp_a;
    assign w_vel[2]   = r_a.item.vel_perp_b;
    assign w_drift[0] = r_a.item.drift_par;
    assign w_drift[1] = r_a.item.drift_perp_a;
    assign w_drift[2] = r_a.item.drift_perp_b;
    assign w_temp[0]  = r_a.item.temp_par;
    assign w_temp[1]  = r_a.item.temp_perp;
    assign w_temp[2]  = r_a.item.temp_perp;

    for (genvar d = 0; d < 3; d++) begin : g_dim
        if (d < MAX_VEL_DIMS) begin : g_on
            bde_sqdiv u_div (
                .i_clk   (i_clk),
                .i_en    (en),
                .i_vel   (w_vel[d]),
                .i_drift (w_drift[d]),
                .i_temp  (w_temp[d]),
                .o_ratio (w_ratio[d])
            );
        end else begin : g_off
            assign w_ratio[d] = '0;
        end
    end

    bde_log2 u_log_n (.i_clk(i_clk), .i_en(en), .i_val(r_a.item.density[30:0]),
                      .o_log(w_ln));
    bde_log2 u_log_tpar (.i_clk(i_clk), .i_en(en), .i_val(r_a.item.temp_par[30:0]),
                         .o_log(w_lt));
    bde_log2 u_log_tperp (.i_clk(i_clk), .i_en(en), .i_val(r_a.item.temp_perp[30:0]),
                          .o_log(w_lp));

    // Ratio sum; every term is already non-negative and capped.
    always_comb begin
        xsum = {2'b0, w_ratio[0]};
        if (r_sb[DIV_LAT].vdim > 2'd1) begin
            xsum = xsum + {2'b0, w_ratio[1]};
        end
        if (r_sb[DIV_LAT].vdim > 2'd2) begin
            xsum = xsum + {2'b0, w_ratio[2]};
        end
    end

    assign xprod = r_x * LOG2E_Q28;

    // 2*lg(n) - lg(Tpar) - (vdim-1)*lg(Tperp) plus the constant part for vdim.
    always_comb begin
        logic signed [35:0] lnx, ltx, lpx;
        lnx = $signed({7'b0, r_lg[LOG_DLY].ln});
        ltx = $signed({7'b0, r_lg[LOG_DLY].lt});
        lpx = $signed({7'b0, r_lg[LOG_DLY].lp});
        case (r_sb[X_TIER].vdim)
            2'd2:    ylog = (lnx <<< 1) - ltx - lpx + Y_K2;
            2'd3:    ylog = (lnx <<< 1) - ltx - (lpx <<< 1) + Y_K3;
            default: ylog = (lnx <<< 1) - ltx + Y_K;
        endcase
    end

    assign gprod     = r_y[24:0] * LN2_Q30;
    assign n_gi.g    = gprod[54:25];
    assign n_gi.sh   = r_y[29:25];
    assign n_gi.zero = r_y[35];
    assign n_gi.sat  = !r_y[35] && (r_y[34:30] != 5'd0);

    assign w_t[0] = ONE_Q30;

    for (genvar j = 0; j < EXP_TERMS; j++) begin : g_term
        localparam int K = EXP_TERMS - j;
        localparam logic [31:0] KC = 32'(K);
        logic [61:0] gt;
        logic [65:0] qm;
        logic [31:0] q0, rem, q;
        logic [30:0] r_p, r_p2;
        logic [65:0] r_qm;
        logic [31:0] r_tn;

        assign gt  = r_gi[3*j].g * w_t[j];
        assign qm  = r_p * EXP_RECIP[K];
        assign q0  = r_qm[65:RECIP_SHIFT];
        assign rem = {1'b0, r_p2} - 32'(q0 * KC);
        assign q   = q0 + {31'b0, (rem >= KC)};

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_p  <= gt[60:30];
                r_qm <= qm;
                r_p2 <= r_p;
                r_tn <= ONE_Q30 + q;
            end
        end

        assign w_t[j+1] = r_tn;
    end

    assign shifted = {31'b0, w_t[EXP_TERMS]} << r_gi[EXP_STAGES].sh;

    always_comb begin
        n_out.nonphysical = r_sb[LAST_TIER].nonphys;
        if (r_sb[LAST_TIER].nonphys || r_gi[EXP_STAGES].zero) begin
            n_out.value = '0;
        end else if (r_gi[EXP_STAGES].sat || (shifted[62:46] != '0)) begin
            n_out.value = 32'hFFFF_FFFF;
        end else begin
            n_out.value = shifted[45:14];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld   <= 1'b0;
            r_out_vld <= 1'b0;
            for (int k = 1; k <= LAST_TIER; k++) begin
                r_sb[k] <= '0;
            end
        end else if (en) begin
            r_a_vld   <= !i_q_stat.empty;
            r_out_vld <= r_sb[LAST_TIER].vld;
            r_sb[1]   <= '{vld: r_a_vld, nonphys: r_a.nonphys, vdim: r_a.vdim};
            for (int k = 2; k <= LAST_TIER; k++) begin
                r_sb[k] <= r_sb[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a     <= i_work;
            r_lg[1] <= '{ln: w_ln, lt: w_lt, lp: w_lp};
            for (int k = 2; k <= LOG_DLY; k++) begin
                r_lg[k] <= r_lg[k-1];
            end
            r_x    <= (xsum > {2'b0, X_CAP}) ? X_CAP : xsum[26:0];
            r_xl   <= xprod[55:23];
            r_ylog <= ylog;
            r_y    <= r_ylog - $signed({3'b0, r_xl});
            r_gi[0] <= n_gi;
            for (int k = 1; k <= EXP_STAGES; k++) begin
                r_gi[k] <= r_gi[k-1];
            end
            r_out  <= n_out;
        end
    end

endmodule
